FILE: hw/rtl/bsc_pkg.sv
`default_nettype none

package bsc_pkg;

  localparam int RAW_W    = 24;
  localparam int COEFF_W  = 16;
  localparam int TEMP_W   = 15;
  localparam int PRES_W   = 17;
  localparam int CFG_IDX_W = 3;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;
  localparam int PIPE_DEPTH  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SENS        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE  = 3'd5;

  localparam logic signed [TEMP_W-1:0] TEMP_MIN = -15'sd4000;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 15'sd8500;
  localparam logic [PRES_W-1:0] PRES_MIN = 17'd1000;
  localparam logic [PRES_W-1:0] PRES_MAX = 17'd120000;

  typedef struct packed {
    logic [COEFF_W-1:0] sens_coeff;
    logic [COEFF_W-1:0] offset_coeff;
    logic [COEFF_W-1:0] sens_temp_coeff;
    logic [COEFF_W-1:0] offset_temp_coeff;
    logic [COEFF_W-1:0] ref_temp_word;
    logic [COEFF_W-1:0] temp_slope_word;
  } cal_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bsc_pipe.sv
`default_nettype none

module bsc_pipe
  import bsc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cal_t              cal,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [RAW_W-1:0]  raw_pressure,
  input  wire logic [RAW_W-1:0]  raw_temperature,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [TEMP_W-1:0]      temp_centi,
  output logic [PRES_W-1:0]      pressure_pa
);

  localparam logic signed [20:0] TEMP_BASE = 21'sd2000;
  localparam logic signed [20:0] TB_OFFS   = 21'sd3500;
  localparam logic signed [18:0] TA_LOW    = -19'sd3500;
  localparam logic signed [20:0] TW_MIN    = -21'sd4000;
  localparam logic signed [20:0] TW_MAX    = 21'sd8500;
  localparam logic signed [30:0] PQ_MIN    = 31'sd1000;
  localparam logic signed [30:0] PQ_MAX    = 31'sd120000;

  typedef struct packed {
    logic [RAW_W-1:0]   d1;
    logic signed [24:0] dt;
  } s1_t;

  typedef struct packed {
    logic [RAW_W-1:0]   d1;
    logic signed [41:0] dtc6;
    logic signed [41:0] c4dt;
    logic signed [41:0] c3dt;
    logic [47:0]        dtsq;
  } s2_t;

  typedef struct packed {
    logic [RAW_W-1:0]   d1;
    logic signed [18:0] ta;
    logic [16:0]        t2;
    logic signed [39:0] off;
    logic signed [39:0] sens;
  } s3_t;

  typedef struct packed {
    logic [RAW_W-1:0]   d1;
    logic               lt_a;
    logic               lt_b;
    logic [35:0]        a;
    logic [35:0]        b;
    logic signed [39:0] off;
    logic signed [39:0] sens;
    logic [TEMP_W-1:0]  temp;
  } s4_t;

  typedef struct packed {
    logic [RAW_W-1:0]   d1;
    logic signed [39:0] offc;
    logic signed [39:0] sensc;
    logic [TEMP_W-1:0]  temp;
  } s5_t;

  typedef struct packed {
    logic [43:0]        p_lo;
    logic signed [44:0] p_hi;
    logic signed [39:0] offc;
    logic [TEMP_W-1:0]  temp;
  } s6_t;

  typedef struct packed {
    logic signed [65:0] prod;
    logic signed [39:0] offc;
    logic [TEMP_W-1:0]  temp;
  } s7_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temp;
    logic [PRES_W-1:0] pres;
  } s8_t;

  logic [PIPE_DEPTH-1:0] v_r, v_nxt, en;

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;
  s4_t s4_r, s4_nxt;
  s5_t s5_r, s5_nxt;
  s6_t s6_r, s6_nxt;
  s7_t s7_r, s7_nxt;
  s8_t s8_r, s8_nxt;

  always_comb begin
    en[PIPE_DEPTH-1] = !v_r[PIPE_DEPTH-1] || out_ready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt = {v_r[PIPE_DEPTH-2:0], in_valid};
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < PIPE_DEPTH; k++) begin
        if (en[k]) begin
          v_r[k] <= v_nxt[k];
        end
      end
    end
  end

  // stage 1: temperature difference
  logic signed [25:0] d2_s, c5_s;
  logic signed [25:0] dt_w;
  assign d2_s = signed'({2'b00, raw_temperature});
  assign c5_s = signed'({2'b00, cal.ref_temp_word, 8'h00});
  assign dt_w = d2_s - c5_s;

  always_comb begin
    s1_nxt.d1 = raw_pressure;
    s1_nxt.dt = dt_w[24:0];
  end

  // stage 2: products of dT
  logic signed [16:0] c6_s, c4_s, c3_s;
  logic signed [41:0] m_dtc6, m_c4dt, m_c3dt;
  logic signed [49:0] m_dtsq;
  assign c6_s   = signed'({1'b0, cal.temp_slope_word});
  assign c4_s   = signed'({1'b0, cal.offset_temp_coeff});
  assign c3_s   = signed'({1'b0, cal.sens_temp_coeff});
  assign m_dtc6 = s1_r.dt * c6_s;
  assign m_c4dt = s1_r.dt * c4_s;
  assign m_c3dt = s1_r.dt * c3_s;
  assign m_dtsq = s1_r.dt * s1_r.dt;

  always_comb begin
    s2_nxt.d1   = s1_r.d1;
    s2_nxt.dtc6 = m_dtc6;
    s2_nxt.c4dt = m_c4dt;
    s2_nxt.c3dt = m_c3dt;
    s2_nxt.dtsq = m_dtsq[47:0];
  end

  // stage 3: first-order terms
  logic signed [41:0] sh_dtc6, sh_c4dt, sh_c3dt;
  logic signed [39:0] off_base, sens_base, off_w, sens_w;
  assign sh_dtc6   = s2_r.dtc6 >>> 23;
  assign sh_c4dt   = s2_r.c4dt >>> 7;
  assign sh_c3dt   = s2_r.c3dt >>> 8;
  assign off_base  = signed'({8'h00, cal.offset_coeff, 16'h0000});
  assign sens_base = signed'({9'h0, cal.sens_coeff, 15'h0});
  assign off_w     = off_base + sh_c4dt[39:0];
  assign sens_w    = sens_base + sh_c3dt[39:0];

  always_comb begin
    s3_nxt.d1   = s2_r.d1;
    s3_nxt.ta   = sh_dtc6[18:0];
    s3_nxt.t2   = s2_r.dtsq[47:31];
    s3_nxt.off  = off_w;
    s3_nxt.sens = sens_w;
  end

  // stage 4: squares and final temperature
  logic signed [20:0] ta_ext, tb, t2_s, tw;
  logic signed [37:0] m_a;
  logic signed [41:0] m_b;
  logic               lt_a_w, lt_b_w;
  assign ta_ext = s3_r.ta;
  assign tb     = ta_ext + TB_OFFS;
  assign lt_a_w = s3_r.ta[18];
  assign lt_b_w = s3_r.ta < TA_LOW;
  assign m_a    = s3_r.ta * s3_r.ta;
  assign m_b    = tb * tb;
  assign t2_s   = lt_a_w ? signed'({4'h0, s3_r.t2}) : 21'sd0;
  assign tw     = ta_ext + TEMP_BASE - t2_s;

  always_comb begin
    s4_nxt.d1   = s3_r.d1;
    s4_nxt.lt_a = lt_a_w;
    s4_nxt.lt_b = lt_b_w;
    s4_nxt.a    = m_a[35:0];
    s4_nxt.b    = m_b[35:0];
    s4_nxt.off  = s3_r.off;
    s4_nxt.sens = s3_r.sens;
    if (tw < TW_MIN) begin
      s4_nxt.temp = TEMP_MIN;
    end else if (tw > TW_MAX) begin
      s4_nxt.temp = TEMP_MAX;
    end else begin
      s4_nxt.temp = tw[TEMP_W-1:0];
    end
  end

  // stage 5: second-order corrections
  logic [39:0] fa, fb, five_a, seven_b, eleven_b, off2, sens2;
  assign fa       = {4'h0, s4_r.a};
  assign fb       = {4'h0, s4_r.b};
  assign five_a   = (fa << 2) + fa;
  assign seven_b  = (fb << 3) - fb;
  assign eleven_b = (fb << 3) + (fb << 1) + fb;
  assign off2     = (s4_r.lt_a ? (five_a >> 1) : 40'd0)
                  + (s4_r.lt_b ? seven_b : 40'd0);
  assign sens2    = (s4_r.lt_a ? (five_a >> 2) : 40'd0)
                  + (s4_r.lt_b ? (eleven_b >> 1) : 40'd0);

  always_comb begin
    s5_nxt.d1    = s4_r.d1;
    s5_nxt.offc  = s4_r.off - signed'(off2);
    s5_nxt.sensc = s4_r.sens - signed'(sens2);
    s5_nxt.temp  = s4_r.temp;
  end

  // stage 6: partial products of D1 * SENS
  logic signed [24:0] d1_s;
  logic signed [19:0] sens_hi;
  logic signed [44:0] m_phi;
  logic [43:0]        m_plo;
  assign d1_s    = signed'({1'b0, s5_r.d1});
  assign sens_hi = signed'(s5_r.sensc[39:20]);
  assign m_phi   = d1_s * sens_hi;
  assign m_plo   = s5_r.d1 * s5_r.sensc[19:0];

  always_comb begin
    s6_nxt.p_lo = m_plo;
    s6_nxt.p_hi = m_phi;
    s6_nxt.offc = s5_r.offc;
    s6_nxt.temp = s5_r.temp;
  end

  // stage 7: combine partial products
  logic signed [65:0] hi_ext, lo_ext;
  assign hi_ext = s6_r.p_hi;
  assign lo_ext = signed'({22'h0, s6_r.p_lo});

  always_comb begin
    s7_nxt.prod = (hi_ext <<< 20) + lo_ext;
    s7_nxt.offc = s6_r.offc;
    s7_nxt.temp = s6_r.temp;
  end

  // stage 8: pressure and saturation
  logic signed [44:0] psh;
  logic signed [45:0] pdiff;
  logic signed [30:0] pq;
  assign psh   = signed'(s7_r.prod[65:21]);
  assign pdiff = psh - s7_r.offc;
  assign pq    = signed'(pdiff[45:15]);

  always_comb begin
    s8_nxt.temp = s7_r.temp;
    if (pq < PQ_MIN) begin
      s8_nxt.pres = PRES_MIN;
    end else if (pq > PQ_MAX) begin
      s8_nxt.pres = PRES_MAX;
    end else begin
      s8_nxt.pres = pq[PRES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) s1_r <= s1_nxt;
    if (en[1]) s2_r <= s2_nxt;
    if (en[2]) s3_r <= s3_nxt;
    if (en[3]) s4_r <= s4_nxt;
    if (en[4]) s5_r <= s5_nxt;
    if (en[5]) s6_r <= s6_nxt;
    if (en[6]) s7_r <= s7_nxt;
    if (en[7]) s8_r <= s8_nxt;
  end

  assign temp_centi  = s8_r.temp;
  assign pressure_pa = s8_r.pres;

endmodule

`default_nettype wire

FILE: hw/rtl/baro_sensor_compensation.sv
// Barometric pressure and temperature compensation, second-order scheme.
// Input stream: one beat carries a raw pressure conversion (D1) and a raw
// temperature conversion (D2). Output stream: one beat per input beat with
// the temperature in 0.01 degC (saturated to -40.00..85.00) and the
// pressure in Pa (saturated to 1000..120000).
// Configuration: six 16-bit calibration words, written by index 0..5 on
// the cfg channel while the block is idle, a rule for the user that the block
// does not enforce; indices 6 and 7 are ignored. cfg_ready is always high.
// Pipeline: an accepted input beat passes to out_tvalid through
// the eight register stages (dT, dT products, first-order terms, squares,
// second-order corrections, split D1*SENS product, product sum, pressure).
// Throughput: one beat per cycle. Each stage advances when the stage after
// it is empty or moving, so bubbles close up; a stalled output holds its
// beat and back-pressure reaches in_tready only once every stage is full.
// Reset: the pipeline is emptied and all calibration words are cleared.
`default_nettype none

module baro_sensor_compensation
  import bsc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [23:0] raw_pressure, [47:24] raw_temperature
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [14:0] temp_centi, [31:15] pressure_pa
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [COEFF_W-1:0]     cfg_data
);

  cal_t cal_r, cal_nxt;
  logic [TEMP_W-1:0] temp_centi;
  logic [PRES_W-1:0] pressure_pa;

  assign cfg_ready = 1'b1;

  always_comb begin
    cal_nxt = cal_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_SENS:        cal_nxt.sens_coeff        = cfg_data;
        REG_OFFSET:      cal_nxt.offset_coeff      = cfg_data;
        REG_SENS_TEMP:   cal_nxt.sens_temp_coeff   = cfg_data;
        REG_OFFSET_TEMP: cal_nxt.offset_temp_coeff = cfg_data;
        REG_REF_TEMP:    cal_nxt.ref_temp_word     = cfg_data;
        REG_TEMP_SLOPE:  cal_nxt.temp_slope_word   = cfg_data;
        default:         cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  bsc_pipe u_pipe (
    .clk             (clk),
    .rst_n           (rst_n),
    .cal             (cal_r),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .raw_pressure    (in_tdata[RAW_W-1:0]),
    .raw_temperature (in_tdata[2*RAW_W-1:RAW_W]),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .temp_centi      (temp_centi),
    .pressure_pa     (pressure_pa)
  );

  assign out_tdata = {pressure_pa, temp_centi};

endmodule

`default_nettype wire

FILE: hw/rtl/bsc_checker.sv
`default_nettype none

module bsc_checker
  import bsc_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output beat changed while stalled");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[TEMP_W-1:0]) >= TEMP_MIN)
                && ($signed(out_tdata[TEMP_W-1:0]) <= TEMP_MAX))
    else $error("temperature outside saturation range");

  a_pres_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[TEMP_W+PRES_W-1:TEMP_W] >= PRES_MIN)
                && (out_tdata[TEMP_W+PRES_W-1:TEMP_W] <= PRES_MAX))
    else $error("pressure outside saturation range");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with output register empty");

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

FILE: tb/baro_sensor_compensation_tb.sv
`timescale 1ns / 1ps

module baro_sensor_compensation_tb;
  import bsc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int STALL_LIMIT = 2000;
  localparam int SEG_ITEMS   = 150;
  localparam int NUM_SEGS    = 9;
  localparam logic [RAW_W-1:0] NOMINAL_D1 = 24'd9085466;
  localparam logic [RAW_W-1:0] NOMINAL_D2 = 24'd8566784;

  localparam cal_t TYPICAL_CAL = '{
    sens_coeff:        16'd40127,
    offset_coeff:      16'd36924,
    sens_temp_coeff:   16'd23317,
    offset_temp_coeff: 16'd23282,
    ref_temp_word:     16'd33464,
    temp_slope_word:   16'd28312
  };

  typedef struct packed {
    logic [PRES_W-1:0]        pres;
    logic signed [TEMP_W-1:0] temp;
  } reading_t;

  class compensation_model;
    cal_t     cal = '0;
    reading_t expected_readings[$];
    int       errors = 0;

    function void load_word(logic [CFG_IDX_W-1:0] idx, logic [COEFF_W-1:0] word);
      case (idx)
        REG_SENS:        cal.sens_coeff = word;
        REG_OFFSET:      cal.offset_coeff = word;
        REG_SENS_TEMP:   cal.sens_temp_coeff = word;
        REG_OFFSET_TEMP: cal.offset_temp_coeff = word;
        REG_REF_TEMP:    cal.ref_temp_word = word;
        REG_TEMP_SLOPE:  cal.temp_slope_word = word;
        default: ;
      endcase
    endfunction

    function void note_conversion(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
      longint   dt, temp, off, sens, t2, off2, sens2, a, b, pres;
      reading_t r;
      dt   = longint'(d2) - longint'(cal.ref_temp_word) * 256;
      temp = 2000 + ((dt * longint'(cal.temp_slope_word)) >>> 23);
      off  = longint'(cal.offset_coeff) * 65536
             + ((longint'(cal.offset_temp_coeff) * dt) >>> 7);
      sens = longint'(cal.sens_coeff) * 32768
             + ((longint'(cal.sens_temp_coeff) * dt) >>> 8);
      t2 = 0;
      off2 = 0;
      sens2 = 0;
      if (temp < 2000) begin
        a     = (temp - 2000) * (temp - 2000);
        t2    = (dt * dt) >>> 31;
        off2  = (5 * a) >>> 1;
        sens2 = (5 * a) >>> 2;
        if (temp < -1500) begin
          b     = (temp + 1500) * (temp + 1500);
          off2  = off2 + 7 * b;
          sens2 = sens2 + ((11 * b) >>> 1);
        end
      end
      temp = temp - t2;
      pres = (((longint'(d1) * (sens - sens2)) >>> 21) - (off - off2)) >>> 15;
      if (temp < longint'(TEMP_MIN)) temp = longint'(TEMP_MIN);
      if (temp > longint'(TEMP_MAX)) temp = longint'(TEMP_MAX);
      if (pres < longint'(PRES_MIN)) pres = longint'(PRES_MIN);
      if (pres > longint'(PRES_MAX)) pres = longint'(PRES_MAX);
      r.temp = temp[TEMP_W-1:0];
      r.pres = pres[PRES_W-1:0];
      expected_readings.push_back(r);
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected beat, actual temp_centi %0d pressure_pa %0d",
                 $time, got.temp, got.pres);
        errors++;
      end else begin
        want = expected_readings.pop_front();
        if (got.temp !== want.temp) begin
          $display("%0t: temp_centi mismatch, expected %0d, actual %0d",
                   $time, want.temp, got.temp);
          errors++;
        end
        if (got.pres !== want.pres) begin
          $display("%0t: pressure_pa mismatch, expected %0d, actual %0d",
                   $time, want.pres, got.pres);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEFF_W-1:0] cfg_data = '0;

  int src_idle = 10;
  int dst_idle = 68;
  int quiet = 0;
  compensation_model sb = new();

  baro_sensor_compensation dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= dst_idle);
  end

  always @(posedge clk) begin
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                  (cfg_valid && cfg_ready))) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (rst_n && cfg_valid && cfg_ready) sb.load_word(cfg_index, cfg_data);
    if (rst_n && in_tvalid && in_tready) sb.note_conversion(in_tdata[23:0], in_tdata[47:24]);
    if (rst_n && out_tvalid && out_tready) sb.check_reading(reading_t'(out_tdata));
    if (quiet >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("** baro_sensor_compensation: FAILED **");
      $finish;
    end
  end

  task automatic send_pair(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
    while ($urandom_range(99) < src_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {d2, d1};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  task automatic write_word(logic [CFG_IDX_W-1:0] idx, logic [COEFF_W-1:0] word);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_cal(cal_t c);
    write_word(REG_SENS, c.sens_coeff);
    write_word(REG_OFFSET, c.offset_coeff);
    write_word(REG_SENS_TEMP, c.sens_temp_coeff);
    write_word(REG_OFFSET_TEMP, c.offset_temp_coeff);
    write_word(REG_REF_TEMP, c.ref_temp_word);
    write_word(REG_TEMP_SLOPE, c.temp_slope_word);
    write_word($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, 16'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    cal_t c;
    int seg, k, i, lim;
    longint ofs, v;
    logic [RAW_W-1:0] d1, d2;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // calibration still at its reset value
    send_pair(24'd0, 24'd0);
    send_pair(24'hFFFFFF, 24'hFFFFFF);
    send_pair(24'($urandom), 24'($urandom));
    drain();

    c = TYPICAL_CAL;
    load_cal(c);
    send_pair(24'd0, 24'd0);
    send_pair(24'hFFFFFF, 24'hFFFFFF);
    send_pair(24'd0, 24'hFFFFFF);
    send_pair(24'hFFFFFF, 24'd0);
    send_pair(NOMINAL_D1, NOMINAL_D2);
    send_pair(NOMINAL_D1, NOMINAL_D2 - 24'd1);
    send_pair(NOMINAL_D1, NOMINAL_D2 + 24'd1);
    send_pair(NOMINAL_D1, NOMINAL_D2 - 24'd1000000);
    send_pair(NOMINAL_D1, NOMINAL_D2 - 24'd1037020);
    send_pair(NOMINAL_D1, NOMINAL_D2 - 24'd1037021);
    send_pair(NOMINAL_D1, NOMINAL_D2 - 24'd1040000);
    send_pair(NOMINAL_D1, NOMINAL_D2 - 24'd2300000);
    send_pair(NOMINAL_D1, NOMINAL_D2 + 24'd2000000);
    send_pair(24'd1, NOMINAL_D2);
    send_pair(24'hFFFFFF, NOMINAL_D2);
    send_pair(24'h800000, NOMINAL_D2);
    send_pair(24'h7FFFFF, NOMINAL_D2 - 24'd500000);
    send_pair(24'hAAAAAA, 24'h555555);
    send_pair(24'h555555, 24'hAAAAAA);
    drain();

    for (seg = 0; seg < NUM_SEGS; seg++) begin
      case (seg / 3)
        0: begin src_idle = 10; dst_idle = 68; end
        1: begin src_idle = 68; dst_idle = 10; end
        default: begin src_idle = 0; dst_idle = 0; end
      endcase
      case (seg)
        0: c = TYPICAL_CAL;
        1: c = '1;
        4: c = '0;
        default: begin
          if (seg % 2 == 0) begin
            for (i = 0; i < 6; i++)
              c[16*i +: 16] = TYPICAL_CAL[16*i +: 16] + 16'($urandom_range(4000)) - 16'd2000;
          end else begin
            c = {$urandom, $urandom, $urandom};
          end
        end
      endcase
      load_cal(c);
      for (k = 0; k < SEG_ITEMS; k++) begin
        if ($urandom_range(3) == 0) begin
          d2 = 24'($urandom);
        end else begin
          case ($urandom_range(2))
            0: lim = 4096;
            1: lim = 1 << 20;
            default: lim = 1 << 22;
          endcase
          ofs = longint'($urandom_range(2 * lim)) - lim;
          v = longint'(c.ref_temp_word) * 256 + ofs;
          if (v < 0) v = 0;
          if (v > 64'hFFFFFF) v = 64'hFFFFFF;
          d2 = v[23:0];
        end
        if ($urandom_range(1)) begin
          d1 = 24'($urandom);
        end else begin
          v = longint'(NOMINAL_D1) + longint'($urandom_range(1 << 21)) - (1 << 20);
          d1 = v[23:0];
        end
        send_pair(d1, d2);
        // hold off until the pipeline has emptied
        if (seg % 3 == 1 && k == SEG_ITEMS / 2) drain();
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("** baro_sensor_compensation: PASSED **");
    end else begin
      $display("** baro_sensor_compensation: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/bsc_pkg.sv
hw/rtl/bsc_pipe.sv
hw/rtl/baro_sensor_compensation.sv
hw/rtl/bsc_checker.sv
tb/baro_sensor_compensation_tb.sv
